[hw/rtl/cts_pkg.sv]
package cts_pkg;

  // lexer scanning modes
  typedef enum logic [3:0] {
    LEX_IDLE       = 4'd0,
    LEX_NUM        = 4'd1,
    LEX_WORD       = 4'd2,
    LEX_OP         = 4'd3,
    LEX_SLASH      = 4'd4,
    LEX_LINE_CMT   = 4'd5,
    LEX_BLOCK_CMT  = 4'd6,
    LEX_BLOCK_STAR = 4'd7,
    LEX_STRING     = 4'd8,
    LEX_STR_ESC    = 4'd9,
    LEX_CHAR_BODY  = 4'd10,
    LEX_CHAR_CLOSE = 4'd11
  } lex_mode_t;

  // most output bytes one source byte can cause
  localparam int unsigned MAX_OUT = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);
  localparam int unsigned SEL_W   = $clog2(MAX_OUT);

  // output bytes caused by one source byte, lowest slot first
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    logic [MAX_OUT-1:0][7:0]   bytes;
  } cts_bundle_t;

  // character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BAR    = 8'h7C;

endpackage

[hw/rtl/cts_front.sv]
module cts_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_end,
  input  logic                 full,
  output logic                 push,
  output cts_pkg::cts_bundle_t bundle
);

  cts_pkg::lex_mode_t mode, mode_next;
  logic [7:0]         held, held_next;
  logic               accept;
  logic               do_begin;
  logic               b_digit, b_alpha, b_num, b_word, b_op;
  logic [cts_pkg::CNT_W-1:0]                out_n;
  logic [cts_pkg::MAX_OUT-1:0][7:0]         out_bytes;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // byte classes
  assign b_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign b_alpha = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
                   ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
  assign b_num   = b_digit || (in_byte == cts_pkg::CH_DOT);
  assign b_word  = b_alpha || b_digit || (in_byte == cts_pkg::CH_UNDER) ||
                   (in_byte == cts_pkg::CH_DASH);
  assign b_op    = in_byte inside {cts_pkg::CH_AMP, cts_pkg::CH_BAR, cts_pkg::CH_LT,
                                   cts_pkg::CH_GT, cts_pkg::CH_STAR, cts_pkg::CH_PLUS,
                                   cts_pkg::CH_DASH, cts_pkg::CH_EQ};

  // byte ends the open token and starts a fresh one
  always_comb begin
    do_begin = 1'b0;
    if (!in_end) begin
      case (mode)
        cts_pkg::LEX_NUM:   do_begin = !b_num;
        cts_pkg::LEX_WORD:  do_begin = !b_word;
        cts_pkg::LEX_OP:    do_begin = !((in_byte == held) || (in_byte == cts_pkg::CH_EQ));
        cts_pkg::LEX_SLASH: do_begin = !(in_byte inside {cts_pkg::CH_SLASH, cts_pkg::CH_STAR,
                                                         cts_pkg::CH_EQ});
        cts_pkg::LEX_LINE_CMT, cts_pkg::LEX_BLOCK_CMT, cts_pkg::LEX_BLOCK_STAR,
        cts_pkg::LEX_STRING, cts_pkg::LEX_STR_ESC, cts_pkg::LEX_CHAR_BODY,
        cts_pkg::LEX_CHAR_CLOSE: do_begin = 1'b0;
        default:            do_begin = 1'b1;
      endcase
    end
  end

  // next state
  always_comb begin
    mode_next = mode;
    held_next = held;
    if (in_end) begin
      mode_next = cts_pkg::LEX_IDLE;
      held_next = 8'h00;
    end else if (do_begin) begin
      held_next = 8'h00;
      case (in_byte)
        cts_pkg::CH_SPACE, cts_pkg::CH_TAB, cts_pkg::CH_NL: mode_next = cts_pkg::LEX_IDLE;
        cts_pkg::CH_SLASH:  mode_next = cts_pkg::LEX_SLASH;
        cts_pkg::CH_SQUOTE: mode_next = cts_pkg::LEX_CHAR_BODY;
        cts_pkg::CH_DQUOTE: mode_next = cts_pkg::LEX_STRING;
        default: begin
          if (b_op) begin
            mode_next = cts_pkg::LEX_OP;
            held_next = in_byte;
          end else if (b_digit) begin
            mode_next = cts_pkg::LEX_NUM;
          end else if (b_alpha) begin
            mode_next = cts_pkg::LEX_WORD;
          end else begin
            mode_next = cts_pkg::LEX_IDLE;
          end
        end
      endcase
    end else begin
      case (mode)
        cts_pkg::LEX_OP: begin
          mode_next = cts_pkg::LEX_IDLE;
          held_next = 8'h00;
        end
        cts_pkg::LEX_SLASH: begin
          if (in_byte == cts_pkg::CH_SLASH) mode_next = cts_pkg::LEX_LINE_CMT;
          else if (in_byte == cts_pkg::CH_STAR) mode_next = cts_pkg::LEX_BLOCK_CMT;
          else mode_next = cts_pkg::LEX_IDLE;
        end
        cts_pkg::LEX_LINE_CMT: begin
          if (in_byte == cts_pkg::CH_NL) mode_next = cts_pkg::LEX_IDLE;
        end
        cts_pkg::LEX_BLOCK_CMT: begin
          if (in_byte == cts_pkg::CH_STAR) mode_next = cts_pkg::LEX_BLOCK_STAR;
        end
        cts_pkg::LEX_BLOCK_STAR: begin
          if (in_byte == cts_pkg::CH_SLASH) mode_next = cts_pkg::LEX_IDLE;
          else if (in_byte != cts_pkg::CH_STAR) mode_next = cts_pkg::LEX_BLOCK_CMT;
        end
        cts_pkg::LEX_STRING: begin
          if (in_byte == cts_pkg::CH_BSLASH) mode_next = cts_pkg::LEX_STR_ESC;
          else if (in_byte == cts_pkg::CH_DQUOTE) mode_next = cts_pkg::LEX_IDLE;
        end
        cts_pkg::LEX_STR_ESC:    mode_next = cts_pkg::LEX_STRING;
        cts_pkg::LEX_CHAR_BODY:  mode_next = cts_pkg::LEX_CHAR_CLOSE;
        cts_pkg::LEX_CHAR_CLOSE: mode_next = cts_pkg::LEX_IDLE;
        default:                 mode_next = mode;
      endcase
    end
  end

  // output bytes: what closes or continues the open token, then a fresh start's bytes or the final newline
  always_comb begin
    out_n     = '0;
    out_bytes = '0;
    if (in_end) begin
      case (mode)
        cts_pkg::LEX_NUM, cts_pkg::LEX_WORD, cts_pkg::LEX_OP: begin
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
        end
        cts_pkg::LEX_SLASH: begin
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_SLASH; out_n = out_n + 1'b1;
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
        end
        cts_pkg::LEX_STRING, cts_pkg::LEX_STR_ESC: begin
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_DQUOTE; out_n = out_n + 1'b1;
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
        end
        cts_pkg::LEX_CHAR_BODY: begin
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_SQUOTE; out_n = out_n + 1'b1;
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
        end
        default: ;
      endcase
      out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
    end else begin
      case (mode)
        cts_pkg::LEX_NUM, cts_pkg::LEX_WORD: begin
          out_bytes[0] = do_begin ? cts_pkg::CH_NL : in_byte; out_n = out_n + 1'b1;
        end
        cts_pkg::LEX_OP: begin
          if (!do_begin) begin
            out_bytes[out_n[cts_pkg::SEL_W-1:0]] = in_byte; out_n = out_n + 1'b1;
          end
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
        end
        cts_pkg::LEX_SLASH: begin
          if (!(in_byte inside {cts_pkg::CH_SLASH, cts_pkg::CH_STAR})) begin
            out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_SLASH; out_n = out_n + 1'b1;
            if (!do_begin) begin
              out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_EQ; out_n = out_n + 1'b1;
            end
            out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
          end
        end
        cts_pkg::LEX_STRING: begin
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = in_byte; out_n = out_n + 1'b1;
          if (in_byte == cts_pkg::CH_DQUOTE) begin
            out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
          end
        end
        cts_pkg::LEX_STR_ESC: begin
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = in_byte; out_n = out_n + 1'b1;
        end
        cts_pkg::LEX_CHAR_BODY: begin
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = in_byte; out_n = out_n + 1'b1;
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_SQUOTE; out_n = out_n + 1'b1;
          out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
        end
        default: ;
      endcase
      if (do_begin) begin
        case (in_byte)
          cts_pkg::CH_SPACE, cts_pkg::CH_TAB, cts_pkg::CH_NL, cts_pkg::CH_SLASH: ;
          cts_pkg::CH_SQUOTE, cts_pkg::CH_DQUOTE: begin
            out_bytes[out_n[cts_pkg::SEL_W-1:0]] = in_byte; out_n = out_n + 1'b1;
          end
          default: begin
            out_bytes[out_n[cts_pkg::SEL_W-1:0]] = in_byte; out_n = out_n + 1'b1;
            if (!b_op && !b_digit && !b_alpha) begin
              out_bytes[out_n[cts_pkg::SEL_W-1:0]] = cts_pkg::CH_NL; out_n = out_n + 1'b1;
            end
          end
        endcase
      end
    end
  end

  // only requests that cause output go to the queue
  assign push         = accept && (out_n != '0);
  assign bundle.count = out_n;
  assign bundle.bytes = out_bytes;

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cts_pkg::LEX_IDLE;
      held <= 8'h00;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

  // a held operator exists only while an operator token is open
  a_held_in_op: assert property (@(posedge clk) disable iff (rst)
    (held != 8'h00) |-> (mode == cts_pkg::LEX_OP))
    else $error("held operator outside operator mode");

  // a stalled front keeps its state
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(mode) && $stable(held)))
    else $error("lexer state moved without a request");

  // end of input always leaves the lexer idle
  a_end_idles: assert property (@(posedge clk) disable iff (rst)
    (accept && in_end) |=> (mode == cts_pkg::LEX_IDLE && held == 8'h00))
    else $error("lexer not idle after end of input");

endmodule

[hw/rtl/cts_queue.sv]
module cts_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cts_pkg::cts_bundle_t wr_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output cts_pkg::cts_bundle_t rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

  cts_pkg::cts_bundle_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   fill;
  logic          do_push, do_pop;

  assign full    = (fill == FULL_CNT);
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  // fill count stays within the depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("queue fill count out of range");

  // stored bundles are never empty
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rd_data.count != '0))
    else $error("queue head holds no bytes");

endmodule

[hw/rtl/cts_back.sv]
module cts_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  cts_pkg::cts_bundle_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic [cts_pkg::SEL_W-1:0] idx;
  logic                      fire;

  assign out_valid = !empty;
  assign out_byte  = head.bytes[idx];
  assign out_last  = ({1'b0, idx} == (head.count - 1'b1));
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;

  // slot within the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= out_last ? '0 : idx + 1'b1;
    end
  end

  // the slot never runs past the bundle's byte count
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, idx} < head.count))
    else $error("serializer slot beyond bundle");

  // a bundle leaves the queue only on its final byte
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == '0))
    else $error("slot not rewound after bundle");

  // slot only moves on a request
  a_idx_stall: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(idx))
    else $error("slot moved without a request");

endmodule

[hw/rtl/c_token_splitter.sv]
// c_token_splitter: splits C source text into tokens, one token per line.
//
// input stream (s_axis_*): one source byte per request in tdata; tlast set
// marks end of input, which flushes the open token and adds a final newline
// (tdata is then ignored).
// output stream (m_axis_*): token bytes and newline separators, one per
// request; tlast marks the final byte caused by one input request.
//
// a front lexer classifies each byte combinationally and pushes the one to
// four bytes it causes, if any, as one bundle into a DEPTH-entry queue; a back
// serializer sends the head bundle one byte per cycle while m_axis_tready is high.
// each output byte is read from the queue, so it is registered before it is sent.
// throughput: one input byte per cycle while the output keeps up; the output
// side moves one byte per cycle while the receiver is ready, so an input
// causing k bytes holds the output for all k of them, and the queue absorbs bursts.
// a stalled receiver fills the queue, then s_axis_tready drops; no bytes are
// lost. reset (rst, synchronous) empties the queue and leaves the lexer idle.
module c_token_splitter #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last
);

  cts_pkg::cts_bundle_t wr_bundle, head;
  logic                 push, full, pop, empty;

  // lexer
  cts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_end   (s_axis_tlast),
    .full     (full),
    .push     (push),
    .bundle   (wr_bundle)
  );

  // bundle queue
  cts_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_bundle),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .rd_data (head)
  );

  // serializer
  cts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
